FILE: hdl/srmm_pkg.sv
// shared types, constants and helpers for the sorted-row matrix median block
// depends on nothing; every other file in hdl/ uses it by scoped names
`timescale 1ns / 1ps

package srmm_pkg;

  // matrix limits and word width
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int DATA_WIDTH  = 32;

  // derived sizes
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W   = $clog2(MAX_COLS + 1);
  localparam int KEY_W       = DATA_WIDTH + 1;

  // configuration port
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = CFG_W'(1);

  // search key: one bit wider than a word so bounds can step past the word range
  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_INIT_LOW  = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam key_t KEY_INIT_HIGH = {2'b11, {(DATA_WIDTH-1){1'b0}}};

  // search sequencer states
  typedef enum logic [2:0] {
    SRCH_IDLE,
    SRCH_MID,
    SRCH_ADDR,
    SRCH_CMP,
    SRCH_DECIDE,
    SRCH_DONE
  } srmm_state_t;

  // job handed from the loader to the search unit
  typedef struct packed {
    logic [ROW_CNT_W-1:0] rows;
    logic [COL_CNT_W-1:0] cols;
    logic [POS_W-1:0]     req;
    key_t                 lo;
    key_t                 hi;
  } srmm_job_t;

  // status returned by the search unit
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DATA_WIDTH-1:0] result;
  } srmm_stat_t;

  // effective row count: zero reads as one, large values clamp
  function automatic logic [ROW_CNT_W-1:0] eff_rows(input logic [CFG_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > MAX_ROWS) begin
      v = MAX_ROWS;
    end
    return v[ROW_CNT_W-1:0];
  endfunction

  // effective column count: zero reads as one, large values clamp
  function automatic logic [COL_CNT_W-1:0] eff_cols(input logic [CFG_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v == 0) begin
      v = 1;
    end else if (v > MAX_COLS) begin
      v = MAX_COLS;
    end
    return v[COL_CNT_W-1:0];
  endfunction

endpackage

FILE: hdl/srmm_store.sv
// element memory: one write port for loading, one registered read port for the search
// depends on srmm_pkg
`timescale 1ns / 1ps

module srmm_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [srmm_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [srmm_pkg::DATA_WIDTH-1:0] wr_data,
  input  logic                           rd_en,
  input  logic [srmm_pkg::ADDR_W-1:0]    rd_addr,
  output logic [srmm_pkg::DATA_WIDTH-1:0] rd_data
);

  logic [srmm_pkg::DATA_WIDTH-1:0] mem [srmm_pkg::STORE_DEPTH];
  logic [srmm_pkg::DATA_WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/srmm_search.sv
// value binary search with per-row upper-bound counting over the element memory
// one shared compare unit, driven by a small sequencer; depends on srmm_pkg
`timescale 1ns / 1ps

module srmm_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  srmm_pkg::srmm_job_t             job,
  input  logic                            take,
  output srmm_pkg::srmm_stat_t            stat,
  output logic                            rd_en,
  output logic [srmm_pkg::ADDR_W-1:0]     rd_addr,
  input  logic [srmm_pkg::DATA_WIDTH-1:0] rd_data
);

  localparam int PW = srmm_pkg::POS_W;
  localparam int RW = srmm_pkg::ROW_CNT_W;
  localparam int CW = srmm_pkg::COL_CNT_W;
  localparam int KW = srmm_pkg::KEY_W;

  srmm_pkg::srmm_state_t state_r, state_nxt;

  logic [RW-1:0]   rows_r, rows_nxt;
  logic [CW-1:0]   cols_r, cols_nxt;
  logic [PW-1:0]   req_r, req_nxt;
  srmm_pkg::key_t  lo_r, lo_nxt;
  srmm_pkg::key_t  hi_r, hi_nxt;
  srmm_pkg::key_t  mid_r, mid_nxt;
  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic [RW-1:0]   row_idx_r, row_idx_nxt;
  logic [PW-1:0]   row_base_r, row_base_nxt;
  logic [CW-1:0]   first_r, first_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic [KW:0]     bound_sum;
  logic [CW-1:0]   step;
  logic [PW-1:0]   probe_addr;
  srmm_pkg::key_t  elem_key;
  logic            elem_le;

  // midpoint: floor of the average, one bit of headroom in the sum
  assign bound_sum = {lo_r[KW-1], lo_r} + {hi_r[KW-1], hi_r};

  // probe position inside the current row
  assign step       = count_r >> 1;
  assign probe_addr = row_base_r + PW'(first_r) + PW'(step);
  assign elem_key   = {rd_data[srmm_pkg::DATA_WIDTH-1], rd_data};
  assign elem_le    = !(mid_r < elem_key);

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srmm_pkg::SRCH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    req_r      <= req_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    cnt_r      <= cnt_nxt;
    row_idx_r  <= row_idx_nxt;
    row_base_r <= row_base_nxt;
    first_r    <= first_nxt;
    count_r    <= count_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    req_nxt      = req_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    mid_nxt      = mid_r;
    cnt_nxt      = cnt_r;
    row_idx_nxt  = row_idx_r;
    row_base_nxt = row_base_r;
    first_nxt    = first_r;
    count_nxt    = count_r;
    rd_en        = 1'b0;
    rd_addr      = probe_addr[srmm_pkg::ADDR_W-1:0];
    stat.busy    = (state_r != srmm_pkg::SRCH_IDLE);
    stat.done    = 1'b0;
    stat.result  = lo_r[srmm_pkg::DATA_WIDTH-1:0];

    case (state_r)
      srmm_pkg::SRCH_IDLE: begin
        if (start) begin
          rows_nxt  = job.rows;
          cols_nxt  = job.cols;
          req_nxt   = job.req;
          lo_nxt    = job.lo;
          hi_nxt    = job.hi;
          state_nxt = srmm_pkg::SRCH_MID;
        end
      end

      // loop test and midpoint, then start counting from the first row
      srmm_pkg::SRCH_MID: begin
        if (hi_r >= lo_r) begin
          mid_nxt      = bound_sum[KW:1];
          cnt_nxt      = '0;
          row_idx_nxt  = '0;
          row_base_nxt = '0;
          first_nxt    = '0;
          count_nxt    = cols_r;
          state_nxt    = srmm_pkg::SRCH_ADDR;
        end else begin
          state_nxt = srmm_pkg::SRCH_DONE;
        end
      end

      // issue the probe read
      srmm_pkg::SRCH_ADDR: begin
        rd_en     = 1'b1;
        state_nxt = srmm_pkg::SRCH_CMP;
      end

      // compare probe against the midpoint and narrow the row window
      srmm_pkg::SRCH_CMP: begin
        if (elem_le) begin
          first_nxt = first_r + step + CW'(1);
          count_nxt = count_r - step - CW'(1);
        end else begin
          count_nxt = step;
        end
        state_nxt = srmm_pkg::SRCH_ADDR;
        if (count_nxt == '0) begin
          cnt_nxt = cnt_r + PW'(first_nxt);
          if (row_idx_r == rows_r - RW'(1)) begin
            state_nxt = srmm_pkg::SRCH_DECIDE;
          end else begin
            row_idx_nxt  = row_idx_r + RW'(1);
            row_base_nxt = row_base_r + PW'(cols_r);
            first_nxt    = '0;
            count_nxt    = cols_r;
          end
        end
      end

      // move one bound past the midpoint
      srmm_pkg::SRCH_DECIDE: begin
        if (req_r >= cnt_r) begin
          lo_nxt = mid_r + KW'(1);
        end else begin
          hi_nxt = mid_r - KW'(1);
        end
        state_nxt = srmm_pkg::SRCH_MID;
      end

      // hold the result until the output register takes it
      srmm_pkg::SRCH_DONE: begin
        stat.done = 1'b1;
        if (take) begin
          state_nxt = srmm_pkg::SRCH_IDLE;
        end
      end

      default: begin
        state_nxt = srmm_pkg::SRCH_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/sorted_row_matrix_median_top.sv
// search: after the final word is loaded the search runs, paced by the one compare unit
//   and the single memory read port; its result is then registered into the output register
// throughput: one word per cycle while loading; no input is taken during the search
// reset: synchronous, active low; both dimensions return to one, loading restarts,
//   the search goes idle and the output valid clears; the element memory is not cleared
`timescale 1ns / 1ps

module sorted_row_matrix_median_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [srmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srmm_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [srmm_pkg::DATA_WIDTH-1:0] in_element_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [srmm_pkg::DATA_WIDTH-1:0] out_median_value
);

  localparam int PW = srmm_pkg::POS_W;
  localparam int RW = srmm_pkg::ROW_CNT_W;
  localparam int CW = srmm_pkg::COL_CNT_W;

  logic [srmm_pkg::CFG_W-1:0] row_reg_r, col_reg_r;
  logic [RW-1:0]              rows;
  logic [CW-1:0]              cols;
  logic [PW-1:0]              total;

  logic [PW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  srmm_pkg::key_t  lo_r, lo_nxt, lo_upd;
  srmm_pkg::key_t  hi_r, hi_nxt, hi_upd;
  srmm_pkg::key_t  word_key;

  logic                  in_accept;
  logic                  last_word;
  logic                  start;
  srmm_pkg::srmm_job_t   job;
  srmm_pkg::srmm_stat_t  stat;
  logic                  take;

  logic                            rd_en;
  logic [srmm_pkg::ADDR_W-1:0]     rd_addr;
  logic [srmm_pkg::DATA_WIDTH-1:0] rd_data;

  logic                            out_valid_r;
  logic [srmm_pkg::DATA_WIDTH-1:0] out_median_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_reg_r <= srmm_pkg::CFG_DIM_RESET;
      col_reg_r <= srmm_pkg::CFG_DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srmm_pkg::REG_ROW_COUNT:    row_reg_r <= cfg_wdata;
        srmm_pkg::REG_COLUMN_COUNT: col_reg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows  = srmm_pkg::eff_rows(row_reg_r);
  assign cols  = srmm_pkg::eff_cols(col_reg_r);
  assign total = PW'(rows) * PW'(cols);

  // load side: track first-column minimum and last-column maximum
  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;
  assign last_word = (pos_r == total - PW'(1));
  assign word_key  = {in_element_value[srmm_pkg::DATA_WIDTH-1], in_element_value};
  assign lo_upd    = ((col_r == '0) && (word_key < lo_r)) ? word_key : lo_r;
  assign hi_upd    = ((col_r == cols - CW'(1)) && (word_key > hi_r)) ? word_key : hi_r;

  always_comb begin
    pos_nxt = pos_r;
    col_nxt = col_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    start   = 1'b0;
    if (cfg_wr_en && (cfg_index == srmm_pkg::REG_ROW_COUNT ||
                      cfg_index == srmm_pkg::REG_COLUMN_COUNT)) begin
      pos_nxt = '0;
      col_nxt = '0;
      lo_nxt  = srmm_pkg::KEY_INIT_LOW;
      hi_nxt  = srmm_pkg::KEY_INIT_HIGH;
    end else if (in_accept) begin
      if (last_word) begin
        start   = 1'b1;
        pos_nxt = '0;
        col_nxt = '0;
        lo_nxt  = srmm_pkg::KEY_INIT_LOW;
        hi_nxt  = srmm_pkg::KEY_INIT_HIGH;
      end else begin
        pos_nxt = pos_r + PW'(1);
        col_nxt = (col_r == cols - CW'(1)) ? '0 : col_r + CW'(1);
        lo_nxt  = lo_upd;
        hi_nxt  = hi_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      col_r <= '0;
      lo_r  <= srmm_pkg::KEY_INIT_LOW;
      hi_r  <= srmm_pkg::KEY_INIT_HIGH;
    end else begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
  end

  // job for the search: bounds include the final word
  assign job.rows = rows;
  assign job.cols = cols;
  assign job.req  = total >> 1;
  assign job.lo   = lo_upd;
  assign job.hi   = hi_upd;

  srmm_store u_store (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (pos_r[srmm_pkg::ADDR_W-1:0]),
    .wr_data (in_element_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srmm_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .job     (job),
    .take    (take),
    .stat    (stat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes the result when empty or being drained
  assign take = stat.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_median_r <= stat.result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_median_r;

endmodule
